/* hw/rtl/flame_sweep_median_locator_macros.svh */
// Assertion macros used by the checker file.
`ifndef FLAME_SWEEP_MEDIAN_LOCATOR_MACROS_SVH
`define FLAME_SWEEP_MEDIAN_LOCATOR_MACROS_SVH

// Property checked on every rising clock edge, ignored while reset is high.
`define FSML_CHECK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property that also covers the reset cycles.
`define FSML_CHECK_RST(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/fsml_pkg.sv */
package fsml_pkg;

   // field widths
   localparam int SAMPLE_W = 10;
   localparam int ANGLE_W  = 8;
   localparam int SUM_W    = 20;
   localparam int HIT_W    = 12;

   // stream word widths
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 24;

   localparam logic [SAMPLE_W-1:0] THRESH_RESET = 10'd100;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SELECT,
      ST_WRAP,
      ST_DIVIDE,
      ST_RESULT
   } state_type;

   // window store / median select control
   typedef struct packed {
      logic wr_en;
      logic start;
   } sel_ctrl_type;

endpackage

/* hw/rtl/fsml_sel.sv */
// Window sample store and MSB-first bit-serial median select.
module fsml_sel #(
   parameter int WINDOW = 5
) (
   input  logic                                clock,
   input  logic                                reset,
   input  fsml_pkg::sel_ctrl_type              ctrl,
   input  logic [$clog2(WINDOW)-1:0]           wr_idx,
   input  logic [fsml_pkg::SAMPLE_W-1:0]       wr_data,
   output logic                                done,
   output logic [fsml_pkg::SAMPLE_W-1:0]       median
);

   localparam int IDX_W   = $clog2(WINDOW);
   localparam int CNT_W   = $clog2(WINDOW + 1);
   localparam int RANK    = (WINDOW - 1) / 2;
   localparam int SW      = fsml_pkg::SAMPLE_W;
   localparam int BIT_W   = $clog2(SW);

   logic [SW-1:0]     entry_ff [WINDOW];
   logic [WINDOW-1:0] active_ff, active_in;
   logic [IDX_W-1:0]  rank_ff, rank_in;
   logic [BIT_W-1:0]  bit_ff;
   logic              busy_ff, done_ff;
   logic [SW-1:0]     median_ff;
   logic [WINDOW-1:0] msb;
   logic [CNT_W-1:0]  zeros;
   logic              res_bit;

   // count live candidates with a 0 in the current bit
   always_comb begin
      zeros = '0;
      for (int i = 0; i < WINDOW; i++) begin
         msb[i] = entry_ff[i][SW-1];
         zeros  = zeros + CNT_W'(active_ff[i] & ~msb[i]);
      end
      if (zeros > CNT_W'(rank_ff)) begin
         res_bit   = 1'b0;
         active_in = active_ff & ~msb;
         rank_in   = rank_ff;
      end else begin
         res_bit   = 1'b1;
         active_in = active_ff & msb;
         rank_in   = rank_ff - IDX_W'(zeros);
      end
   end

   // sample store: write one entry, or rotate all left while selecting
   always_ff @(posedge clock) begin
      for (int i = 0; i < WINDOW; i++) begin
         if (ctrl.wr_en) begin
            if (wr_idx == IDX_W'(i)) begin
               entry_ff[i] <= wr_data;
            end
         end else if (busy_ff) begin
            entry_ff[i] <= {entry_ff[i][SW-2:0], entry_ff[i][SW-1]};
         end
      end
   end

   // select sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         bit_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctrl.start) begin
            busy_ff <= 1'b1;
            bit_ff  <= BIT_W'(SW - 1);
         end else if (busy_ff) begin
            bit_ff <= bit_ff - 1'b1;
            if (bit_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // candidate set, rank and result bits
   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         active_ff <= '1;
         rank_ff   <= IDX_W'(RANK);
      end else if (busy_ff) begin
         active_ff <= active_in;
         rank_ff   <= rank_in;
         median_ff <= {median_ff[SW-2:0], res_bit};
      end
   end

   assign done   = done_ff;
   assign median = median_ff;

endmodule

/* hw/rtl/fsml_div.sv */
// Restoring bit-serial divider, one quotient bit per cycle, result clamped to 8 bits.
module fsml_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [fsml_pkg::SUM_W-1:0]     dividend,
   input  logic [fsml_pkg::HIT_W-1:0]     divisor,
   output logic                           done,
   output logic [fsml_pkg::ANGLE_W-1:0]   quotient
);

   localparam int QW    = fsml_pkg::SUM_W;
   localparam int RW    = fsml_pkg::HIT_W;
   localparam int AW    = fsml_pkg::ANGLE_W;
   localparam int CNT_W = $clog2(QW);

   logic [QW-1:0]    quot_ff, quot_in;
   logic [RW-1:0]    rem_ff, rem_in, divisor_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff, done_ff;
   logic [RW:0]      trial, diff;
   logic             fits;

   // one restoring step
   always_comb begin
      trial   = {rem_ff, quot_ff[QW-1]};
      diff    = trial - {1'b0, divisor_ff};
      fits    = trial >= {1'b0, divisor_ff};
      rem_in  = fits ? diff[RW-1:0] : trial[RW-1:0];
      quot_in = {quot_ff[QW-2:0], fits};
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(QW - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         quot_ff    <= dividend;
         rem_ff     <= '0;
         divisor_ff <= divisor;
      end else if (busy_ff) begin
         quot_ff <= quot_in;
         rem_ff  <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = (|quot_ff[QW-1:AW]) ? '1 : quot_ff[AW-1:0];

endmodule

/* hw/rtl/flame_sweep_median_locator.sv */
// Channel | Dir | Signals                          | Word
// req     | in  | req_tvalid/tready/tdata/tuser/tlast | sample, level, angle; first; last
// rsp     | out | rsp_tvalid/tready/tdata/tuser/tlast | median, vote, here, found, angle; valid; done
// csr     | in  | csr_valid/ready/data             | flame_threshold
//
// Steps: an item that neither fills a window nor ends a sweep is taken in IDLE; a
// window-filling item runs the 10-bit MSB-first median select, a sweep end passes WRAP,
// and the 20-bit serial divider runs after WRAP when there are hits.
// One result word waits in the output register while the next item is taken; a stalled
// word holds the following result in the result step.
// Synchronous reset clears sum, hits, found flag and fill count; threshold returns to 100.
module flame_sweep_median_locator #(
   parameter int WINDOW = 5
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [9:0] sample, [10] digital_level, [18:11] servo_angle
   input  logic [fsml_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // [0] first_of_sweep
   input  logic [0:0]                           req_tuser,
   input  logic                                 req_tlast,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [9:0] median_level, [10] digital_vote, [11] flame_here, [12] flame_found,
   // [20:13] flame_angle
   output logic [fsml_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // [0] window_valid
   output logic [0:0]                           rsp_tuser,
   output logic                                 rsp_tlast,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [fsml_pkg::SAMPLE_W-1:0]        csr_data
);

   localparam int IDX_W    = $clog2(WINDOW);
   localparam int CNT_W    = $clog2(WINDOW + 1);
   localparam int RANK     = (WINDOW - 1) / 2;
   localparam int VOTE_MIN = WINDOW - RANK;
   localparam int SW       = fsml_pkg::SAMPLE_W;
   localparam int AW       = fsml_pkg::ANGLE_W;
   localparam int SUMW     = fsml_pkg::SUM_W;
   localparam int HW       = fsml_pkg::HIT_W;

   fsml_pkg::state_type    state_ff, state_in;
   fsml_pkg::sel_ctrl_type sel_ctrl;

   logic [SW-1:0]     req_sample;
   logic              req_dig;
   logic [AW-1:0]     req_angle;
   logic              req_first;
   logic              accept;
   logic [IDX_W-1:0]  fill_ff, fill_eff;
   logic              complete;
   logic [WINDOW-1:0] dig_ff, dig_in;
   logic [CNT_W-1:0]  ones;
   logic              vote_now;

   logic [AW-1:0]     angle_ff;
   logic              last_ff, valid_ff, vote_ff, here_ff;
   logic [SW-1:0]     thresh_ff;
   logic [SUMW-1:0]   sum_ff;
   logic [SUMW:0]     sum_wide;
   logic [HW-1:0]     hits_ff;
   logic              found_ff;
   logic              here_now;

   logic              sel_done;
   logic [SW-1:0]     sel_median;
   logic              div_start, div_done;
   logic [AW-1:0]     div_quot;
   logic              accum_en, out_load, tready;

   logic              rsp_valid_ff;
   logic [fsml_pkg::RSP_TDATA_W-1:0] rsp_data_ff;
   logic              rsp_user_ff, rsp_last_ff;
   logic [SW-1:0]     out_median;
   logic [AW-1:0]     out_angle;

   // input word unpack
   assign req_sample = req_tdata[9:0];
   assign req_dig    = req_tdata[10];
   assign req_angle  = req_tdata[18:11];
   assign req_first  = req_tuser[0];
   assign accept     = req_tvalid && tready;

   // window fill position and digital vote
   always_comb begin
      fill_eff = req_first ? '0 : fill_ff;
      complete = (fill_eff == IDX_W'(WINDOW - 1));
      ones     = '0;
      for (int i = 0; i < WINDOW; i++) begin
         dig_in[i] = (fill_eff == IDX_W'(i)) ? req_dig : dig_ff[i];
         ones      = ones + CNT_W'(dig_in[i]);
      end
      vote_now = (ones >= CNT_W'(VOTE_MIN));
   end

   // flame test and saturating sum
   assign here_now = (sel_median <= thresh_ff);
   assign sum_wide = {1'b0, sum_ff} + (SUMW + 1)'(angle_ff);

   // sequencer: next state and strobes
   always_comb begin
      state_in  = state_ff;
      tready    = 1'b0;
      sel_ctrl  = '0;
      div_start = 1'b0;
      accum_en  = 1'b0;
      out_load  = 1'b0;
      case (state_ff)
         fsml_pkg::ST_IDLE: begin
            tready         = 1'b1;
            sel_ctrl.wr_en = req_tvalid;
            if (req_tvalid) begin
               if (complete) begin
                  sel_ctrl.start = 1'b1;
                  state_in       = fsml_pkg::ST_SELECT;
               end else if (req_tlast) begin
                  state_in = fsml_pkg::ST_WRAP;
               end
            end
         end
         fsml_pkg::ST_SELECT: begin
            if (sel_done) begin
               accum_en = 1'b1;
               state_in = last_ff ? fsml_pkg::ST_WRAP : fsml_pkg::ST_RESULT;
            end
         end
         fsml_pkg::ST_WRAP: begin
            if (hits_ff != '0) begin
               div_start = 1'b1;
               state_in  = fsml_pkg::ST_DIVIDE;
            end else begin
               state_in = fsml_pkg::ST_RESULT;
            end
         end
         fsml_pkg::ST_DIVIDE: begin
            if (div_done) begin
               state_in = fsml_pkg::ST_RESULT;
            end
         end
         fsml_pkg::ST_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               out_load = 1'b1;
               state_in = fsml_pkg::ST_IDLE;
            end
         end
         default: state_in = fsml_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fsml_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // item registers
   always_ff @(posedge clock) begin
      if (accept) begin
         angle_ff <= req_angle;
         last_ff  <= req_tlast;
         valid_ff <= complete;
         vote_ff  <= vote_now;
         dig_ff   <= dig_in;
         here_ff  <= 1'b0;
      end else if (accum_en) begin
         here_ff <= here_now;
      end
   end

   // fill count, threshold, sweep accumulators
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         thresh_ff <= fsml_pkg::THRESH_RESET;
         sum_ff    <= '0;
         hits_ff   <= '0;
         found_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            thresh_ff <= csr_data;
         end
         if (accept) begin
            fill_ff <= (complete || req_tlast) ? '0 : IDX_W'(fill_eff + 1'b1);
            if (req_first) begin
               sum_ff   <= '0;
               hits_ff  <= '0;
               found_ff <= 1'b0;
            end
         end
         if (accum_en && here_now) begin
            found_ff <= 1'b1;
            sum_ff   <= sum_wide[SUMW] ? '1 : sum_wide[SUMW-1:0];
            if (hits_ff != '1) begin
               hits_ff <= hits_ff + 1'b1;
            end
         end
      end
   end

   fsml_sel #(
      .WINDOW (WINDOW)
   ) u_sel (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (sel_ctrl),
      .wr_idx  (fill_eff),
      .wr_data (req_sample),
      .done    (sel_done),
      .median  (sel_median)
   );

   fsml_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (hits_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   // result word fields
   assign out_median = valid_ff ? sel_median : '0;
   assign out_angle  = (last_ff && (hits_ff != '0)) ? div_quot : '0;

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= {3'b000, out_angle, found_ff, here_ff, valid_ff & vote_ff, out_median};
         rsp_user_ff <= valid_ff;
         rsp_last_ff <= last_ff;
      end
   end

   assign req_tready = tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* hw/rtl/fsml_checker.sv */
`include "flame_sweep_median_locator_macros.svh"

// Port-level checks on the result channel.
module fsml_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready,
   input logic [fsml_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   input logic [0:0]                           rsp_tuser,
   input logic                                 rsp_tlast
);

   logic [fsml_pkg::RSP_TDATA_W+1:0] rsp_word;

   // whole result word as seen on the ports
   assign rsp_word = {rsp_tlast, rsp_tuser, rsp_tdata};

   // no result word right after reset
   `FSML_CHECK_RST(a_reset_idle, clock, reset |=> !rsp_tvalid, "result word valid after reset")

   // a stalled result word holds
   `FSML_CHECK(a_stall_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_word), "stalled word changed")

   // every word is a window result or a sweep end
   `FSML_CHECK(a_word_cause, clock, reset, rsp_tvalid |-> rsp_tuser[0] || rsp_tlast, "result word with no cause")

   // without a window the window fields are zero
   `FSML_CHECK(a_no_window_zero, clock, reset, rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[11:0] == 12'd0, "window fields set")

   // flame in this window implies flame found in the sweep
   `FSML_CHECK(a_here_found, clock, reset, rsp_tvalid && rsp_tdata[11] |-> rsp_tdata[12], "found flag clear")

endmodule

bind flame_sweep_median_locator fsml_checker u_fsml_checker (.*);
